>>> design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef logic [31:0] word_type;
   typedef logic [0:7][31:0] hash_type;   // index 0 is word a / H0

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_FINAL,
      ST_OUT
   } state_type;

   // schedule memory control: round issue plus block word loading
   typedef struct packed {
      logic       issue_en;
      logic [5:0] issue_idx;
      logic       load_en;
      logic [3:0] load_addr;
      word_type   load_data;
   } sched_ctl_type;

   typedef struct packed {
      logic       init;
      logic       round_en;
      logic [5:0] round_idx;
   } round_ctl_type;

   localparam logic       KIND_DATA   = 1'b0;
   localparam logic       KIND_FINISH = 1'b1;
   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [5:0] LAST_POS    = 6'd63;
   localparam logic [6:0] COMP_LAST   = 7'd65;
   localparam logic [6:0] ISSUE_END   = 7'd64;
   localparam logic [6:0] ROUND_START = 7'd2;

   localparam hash_type INIT_HASH = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sig0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sig0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sig1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

>>> design/sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// SHA-256 over a byte stream; emits the eight digest words per message.
// ----------------------------------------------------------------------------
// Request channel (req_*): one byte per request. req_tuser = 0 carries a
// message byte in req_tdata; req_tuser = 1 finishes the message.
// Response channel (rsp_*): eight digest words per finished message, word 0
// first, rsp_tlast on the eighth.
// A data byte is taken whenever the core is idle. Each 64th byte starts a
// compression that holds req_tready low (two-stage schedule read/expand
// pipeline feeding one round per cycle, plus the final hash add).
// A finish request writes pad, zero fill and length one byte per cycle up
// to the block end (64 - fill bytes, or that plus 64 when the length does not
// fit), runs one or two compressions, then presents the digest words at one
// per cycle while rsp_tready is high. A stalled receiver just holds the
// current word; no new request is taken until all eight are delivered.
// After the last word the hash state returns to the initial values.
// Reset (synchronous, active high) clears byte counts and loads the initial
// hash; the block memory needs no clearing.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tuser,    // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [31:0] digest_word, [34:32] word_index
   output logic        rsp_tlast
);

   sha256_pkg::state_type state_ff, state_in;
   logic [6:0]            cyc_ff, cyc_in;
   logic [5:0]            fill_ff, fill_in;
   logic [60:0]           count_ff, count_in;
   logic [23:0]           acc_ff, acc_in;
   sha256_pkg::hash_type  hash_ff, hash_in;
   logic                  pad_first_ff, pad_first_in;
   logic                  len_blk_ff, len_blk_in;
   logic                  done_ff, done_in;
   logic                  padding_ff, padding_in;
   logic [2:0]            oidx_ff, oidx_in;

   logic                  push_en;
   logic [7:0]            push_byte;
   logic [63:0]           bit_len;
   logic [2:0]            len_sel;
   logic [7:0]            len_byte;

   sha256_pkg::sched_ctl_type sched_ctl;
   sha256_pkg::round_ctl_type round_ctl;
   sha256_pkg::word_type      sched_w;
   sha256_pkg::hash_type      work;

   assign bit_len  = {count_ff, 3'b000};
   assign len_sel  = ~fill_ff[2:0];
   assign len_byte = bit_len[{len_sel, 3'b000} +: 8];

   always_comb begin
      state_in     = state_ff;
      cyc_in       = cyc_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      hash_in      = hash_ff;
      pad_first_in = pad_first_ff;
      len_blk_in   = len_blk_ff;
      done_in      = done_ff;
      padding_in   = padding_ff;
      oidx_in      = oidx_ff;
      push_en      = 1'b0;
      push_byte    = req_tdata;
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      round_ctl    = '0;
      sched_ctl    = '0;

      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == sha256_pkg::KIND_DATA) begin
                  push_en  = 1'b1;
                  count_in = count_ff + 61'd1;
               end else begin
                  state_in     = sha256_pkg::ST_PAD;
                  padding_in   = 1'b1;
                  pad_first_in = 1'b1;
                  done_in      = 1'b0;
                  len_blk_in   = (fill_ff < sha256_pkg::LEN_POS);
               end
            end
         end
         sha256_pkg::ST_PAD: begin
            push_en      = 1'b1;
            pad_first_in = 1'b0;
            if (pad_first_ff) begin
               push_byte = sha256_pkg::PAD_BYTE;
            end else if (len_blk_ff && (fill_ff >= sha256_pkg::LEN_POS)) begin
               push_byte = len_byte;
            end else begin
               push_byte = 8'h00;
            end
            if (len_blk_ff && (fill_ff == sha256_pkg::LAST_POS)) begin
               done_in = 1'b1;
            end
         end
         sha256_pkg::ST_COMP: begin
            cyc_in              = cyc_ff + 7'd1;
            sched_ctl.issue_en  = (cyc_ff < sha256_pkg::ISSUE_END);
            sched_ctl.issue_idx = cyc_ff[5:0];
            round_ctl.init      = (cyc_ff == 7'd0);
            round_ctl.round_en  = (cyc_ff >= sha256_pkg::ROUND_START);
            round_ctl.round_idx = 6'(cyc_ff - sha256_pkg::ROUND_START);
            if (cyc_ff == sha256_pkg::COMP_LAST) begin
               state_in = sha256_pkg::ST_FINAL;
            end
         end
         sha256_pkg::ST_FINAL: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work[i];
            end
            if (!padding_ff) begin
               state_in = sha256_pkg::ST_IDLE;
            end else if (done_ff) begin
               state_in = sha256_pkg::ST_OUT;
               oidx_in  = 3'd0;
            end else begin
               // pad byte landed in the length field: second block
               state_in   = sha256_pkg::ST_PAD;
               len_blk_in = 1'b1;
            end
         end
         sha256_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  state_in   = sha256_pkg::ST_IDLE;
                  hash_in    = sha256_pkg::INIT_HASH;
                  count_in   = '0;
                  fill_in    = '0;
                  padding_in = 1'b0;
                  done_in    = 1'b0;
               end
            end
         end
         default: begin
            state_in = sha256_pkg::ST_IDLE;
         end
      endcase

      // byte assembly into big-endian words of the block memory
      if (push_en) begin
         acc_in  = {acc_ff[15:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'b11) begin
            sched_ctl.load_en   = 1'b1;
            sched_ctl.load_addr = fill_ff[5:2];
            sched_ctl.load_data = {acc_ff, push_byte};
         end
         if (fill_ff == sha256_pkg::LAST_POS) begin
            state_in = sha256_pkg::ST_COMP;
            cyc_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha256_pkg::ST_IDLE;
         cyc_ff       <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         hash_ff      <= sha256_pkg::INIT_HASH;
         pad_first_ff <= 1'b0;
         len_blk_ff   <= 1'b0;
         done_ff      <= 1'b0;
         padding_ff   <= 1'b0;
         oidx_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         cyc_ff       <= cyc_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         hash_ff      <= hash_in;
         pad_first_ff <= pad_first_in;
         len_blk_ff   <= len_blk_in;
         done_ff      <= done_in;
         padding_ff   <= padding_in;
         oidx_ff      <= oidx_in;
      end
      acc_ff <= acc_in;
   end

   sha256_sched u_sched (
      .clock (clock),
      .reset (reset),
      .ctl   (sched_ctl),
      .w_out (sched_w)
   );

   sha256_round u_round (
      .clock    (clock),
      .ctl      (round_ctl),
      .hash_in  (hash_ff),
      .w_in     (sched_w),
      .work_out (work)
   );

   assign rsp_tdata = {5'b00000, oidx_ff, hash_ff[oidx_ff]};
   assign rsp_tlast = (oidx_ff == 3'd7);

endmodule

>>> design/sha256_sched.sv
// ----------------------------------------------------------------------------
// sha256_sched
// Message schedule: 16-word memory holding the block, two read ports, one
// write port; expands W[t] in place, one word per cycle, registered.
// ----------------------------------------------------------------------------
module sha256_sched (
   input  logic                      clock,
   input  logic                      reset,
   input  sha256_pkg::sched_ctl_type ctl,
   output sha256_pkg::word_type      w_out
);

   sha256_pkg::word_type sched_mem [16];

   sha256_pkg::word_type rd_a_ff, rd_b_ff;
   sha256_pkg::word_type w_ff, w_in;
   sha256_pkg::word_type w1_ff, w2_ff, w16_ff;
   logic                 cmp_v_ff;
   logic [5:0]           cmp_idx_ff;

   logic [3:0] addr_a, addr_b;
   logic       wr_en;
   logic [3:0] wr_addr;
   sha256_pkg::word_type wr_data;

   // early rounds read W[t] directly; later rounds read W[t-15] and W[t-7]
   always_comb begin
      if (ctl.issue_idx[5:4] == 2'b00) begin
         addr_a = ctl.issue_idx[3:0];
         addr_b = 4'd0;                 // W[0] for the t-16 tap of round 16
      end else begin
         addr_a = ctl.issue_idx[3:0] + 4'd1;
         addr_b = ctl.issue_idx[3:0] + 4'd9;
      end
   end

   always_comb begin
      if (cmp_idx_ff[5:4] == 2'b00) begin
         w_in = rd_a_ff;
      end else begin
         w_in = w16_ff + sha256_pkg::small_sig0(rd_a_ff) + rd_b_ff
              + sha256_pkg::small_sig1(w2_ff);
      end
   end

   always_comb begin
      if (cmp_v_ff && (cmp_idx_ff[5:4] != 2'b00)) begin
         wr_en   = 1'b1;
         wr_addr = cmp_idx_ff[3:0];
         wr_data = w_in;
      end else begin
         wr_en   = ctl.load_en;
         wr_addr = ctl.load_addr;
         wr_data = ctl.load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sched_mem[wr_addr] <= wr_data;
      end
      if (ctl.issue_en) begin
         rd_a_ff <= sched_mem[addr_a];
         rd_b_ff <= sched_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_v_ff <= 1'b0;
      end else begin
         cmp_v_ff <= ctl.issue_en;
      end
      cmp_idx_ff <= ctl.issue_idx;
      if (cmp_v_ff) begin
         w_ff   <= w_in;
         w1_ff  <= w_in;
         w2_ff  <= w1_ff;
         w16_ff <= (cmp_idx_ff == 6'd15) ? rd_b_ff : rd_a_ff;
      end
   end

   assign w_out = w_ff;

endmodule

>>> design/sha256_round.sv
// ----------------------------------------------------------------------------
// sha256_round
// Compression round unit: working variables a..h, one round per cycle.
// ----------------------------------------------------------------------------
module sha256_round (
   input  logic                      clock,
   input  sha256_pkg::round_ctl_type ctl,
   input  sha256_pkg::hash_type      hash_in,
   input  sha256_pkg::word_type      w_in,
   output sha256_pkg::hash_type      work_out
);

   sha256_pkg::hash_type work_ff, work_in;
   sha256_pkg::word_type t1, t2;
   sha256_pkg::word_type ch, maj;

   always_comb begin
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
          ^ (work_ff[1] & work_ff[2]);
      t1  = work_ff[7] + sha256_pkg::big_sig1(work_ff[4]) + ch
          + sha256_pkg::ROUND_K[ctl.round_idx] + w_in;
      t2  = sha256_pkg::big_sig0(work_ff[0]) + maj;
      work_in    = work_ff;
      if (ctl.init) begin
         work_in = hash_in;
      end else if (ctl.round_en) begin
         work_in[0] = t1 + t2;
         work_in[1] = work_ff[0];
         work_in[2] = work_ff[1];
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3] + t1;
         work_in[5] = work_ff[4];
         work_in[6] = work_ff[5];
         work_in[7] = work_ff[6];
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign work_out = work_ff;

endmodule
